@@ src/sha256_message_hasher_macros.svh @@
// ----------------------------------------------------------------------------
// SHA-256 hasher assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  typedef logic [7:0][31:0] hvec_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [31:0] data;
  } wmem_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_LOAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] BLK_LAST  = 6'd63;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] idx);
    logic [63:0][31:0] tbl;
    tbl = {
      32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
      32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
      32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
      32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
      32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
      32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
      32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
      32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
      32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
      32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
      32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
      32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
      32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
      32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
      32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
      32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };
    return tbl[idx];
  endfunction

endpackage

`default_nettype wire

@@ src/sha_wmem.sv @@
// ----------------------------------------------------------------------------
// sha_wmem
// 16 x 32 block word memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_wmem (
  input  wire logic              clk,
  input  wire sha_pkg::wmem_wr_t wr,
  input  wire logic [3:0]        raddr,
  output logic [31:0]            rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/sha_round.sv @@
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round and one message schedule step.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_round (
  input  wire sha_pkg::hvec_t vars,
  input  wire logic [31:0]    kw,
  input  wire logic [31:0]    w0,
  input  wire logic [31:0]    w1,
  input  wire logic [31:0]    w9,
  input  wire logic [31:0]    w14,
  output sha_pkg::hvec_t      vars_next,
  output logic [31:0]         w_new
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] bs0, bs1, ch, maj, t1, t2, ss0, ss1;

  assign {h, g, f, e, d, c, b, a} = vars;

  assign bs1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign bs0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch  = (e & f) ^ (~e & g);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t1  = h + bs1 + ch + kw + w0;
  assign t2  = bs0 + maj;

  assign vars_next = {g, f, e, d + t1, c, b, a, t1 + t2};

  assign ss0   = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
  assign ss1   = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
  assign w_new = ss1 + w9 + ss0 + w0;

endmodule

`default_nettype wire

@@ src/sha256_message_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Byte-serial SHA-256: buffers blocks in word memory, compresses, pads and
// streams the digest.
// ----------------------------------------------------------------------------
//  channel | dir | payload          | handshake
//  msg     | in  | sha_pkg::msg_t   | msg_valid / msg_stall
//  dig     | out | sha_pkg::dig_t   | dig_valid / dig_stall
//
//  A byte request is accepted in the cycle it is offered while idle; each
//  full block then holds input through 16 word reads from block memory
//  (plus the registered read latency), 64 rounds and one hash update.
//  End of message: padding, then one or two compressions, then eight
//  digest words, one per cycle when dig_stall is low.
//  Reset (rst, synchronous) loads the initial hash and clears the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           msg_valid,
  output logic                msg_stall,
  input  wire sha_pkg::msg_t  msg,
  output logic                dig_valid,
  input  wire logic           dig_stall,
  output sha_pkg::dig_t       dig
);

  sha_pkg::state_t  state, state_next, ret;
  sha_pkg::hvec_t   hash, vars, vars_next;
  logic [63:0]      cnt, len;
  logic [23:0]      acc;
  logic [5:0]       cyc;
  logic [2:0]       widx;
  logic [15:0][31:0] w;
  logic [31:0]      w_new, rdata;
  sha_pkg::wmem_wr_t wr;
  logic             acc_in, absorb_en, full, load_word;
  logic [7:0]       absorb_byte;
  logic [2:0]       lbsel;

  assign acc_in    = msg_valid && !msg_stall;
  assign msg_stall = (state != sha_pkg::S_IDLE);
  assign lbsel     = 3'd7 - cnt[2:0];
  assign load_word = (state == sha_pkg::S_OUT) && (!dig_valid || !dig_stall);

  // absorb path and memory write
  always_comb begin
    absorb_en   = 1'b0;
    absorb_byte = 8'd0;
    unique case (state)
      sha_pkg::S_IDLE: begin
        absorb_en   = acc_in && msg.byte_present;
        absorb_byte = msg.msg_byte;
      end
      sha_pkg::S_PAD80: begin
        absorb_en   = 1'b1;
        absorb_byte = sha_pkg::PAD_MARK;
      end
      sha_pkg::S_PADZ: begin
        absorb_en   = (cnt[5:0] != sha_pkg::LEN_START);
      end
      sha_pkg::S_PADLEN: begin
        absorb_en   = 1'b1;
        absorb_byte = len[{lbsel, 3'b000} +: 8];
      end
      default: begin
        absorb_en   = 1'b0;
      end
    endcase
    full    = absorb_en && (cnt[5:0] == sha_pkg::BLK_LAST);
    wr.we   = absorb_en && (cnt[1:0] == 2'd3);
    wr.addr = cnt[5:2];
    wr.data = {acc, absorb_byte};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::S_IDLE: begin
        if (acc_in) begin
          if (full) state_next = sha_pkg::S_LOAD;
          else if (msg.end_of_message) state_next = sha_pkg::S_PAD80;
        end
      end
      sha_pkg::S_PAD80: begin
        state_next = full ? sha_pkg::S_LOAD : sha_pkg::S_PADZ;
      end
      sha_pkg::S_PADZ: begin
        if (cnt[5:0] == sha_pkg::LEN_START) state_next = sha_pkg::S_PADLEN;
        else if (full) state_next = sha_pkg::S_LOAD;
      end
      sha_pkg::S_PADLEN: begin
        if (full) state_next = sha_pkg::S_LOAD;
      end
      sha_pkg::S_LOAD: begin
        if (cyc == 6'd16) state_next = sha_pkg::S_ROUND;
      end
      sha_pkg::S_ROUND: begin
        if (cyc == 6'd63) state_next = sha_pkg::S_ADD;
      end
      sha_pkg::S_ADD: begin
        state_next = ret;
      end
      sha_pkg::S_OUT: begin
        if (load_word && widx == 3'd7) state_next = sha_pkg::S_IDLE;
      end
      default: state_next = sha_pkg::S_IDLE;
    endcase
  end

  sha_wmem u_wmem (
    .clk   (clk),
    .wr    (wr),
    .raddr (cyc[3:0]),
    .rdata (rdata)
  );

  sha_round u_round (
    .vars      (vars),
    .kw        (sha_pkg::k_const(cyc)),
    .w0        (w[0]),
    .w1        (w[1]),
    .w9        (w[9]),
    .w14       (w[14]),
    .vars_next (vars_next),
    .w_new     (w_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_pkg::S_IDLE;
      ret       <= sha_pkg::S_IDLE;
      cnt       <= 64'd0;
      cyc       <= 6'd0;
      widx      <= 3'd0;
      dig_valid <= 1'b0;
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::h_init(3'(i));
    end else begin
      state <= state_next;
      if (absorb_en) begin
        cnt <= cnt + 64'd1;
        acc <= {acc[15:0], absorb_byte};
      end
      if (state == sha_pkg::S_IDLE && acc_in && msg.end_of_message) begin
        len <= (cnt + 64'(msg.byte_present)) << 3;
      end
      if (full) begin
        unique case (state)
          sha_pkg::S_IDLE:   ret <= msg.end_of_message ? sha_pkg::S_PAD80 : sha_pkg::S_IDLE;
          sha_pkg::S_PADLEN: ret <= sha_pkg::S_OUT;
          default:           ret <= sha_pkg::S_PADZ;
        endcase
      end
      if (state_next != state) cyc <= 6'd0;
      else cyc <= cyc + 6'd1;
      if (state == sha_pkg::S_LOAD) begin
        if (cyc == 6'd0) vars <= hash;
        else w <= {rdata, w[15:1]};
      end
      if (state == sha_pkg::S_ROUND) begin
        vars <= vars_next;
        w    <= {w_new, w[15:1]};
      end
      if (state == sha_pkg::S_ADD) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + vars[i];
      end
      if (load_word) begin
        dig_valid       <= 1'b1;
        dig.digest_word <= hash[widx];
        dig.word_index  <= widx;
        dig.last_word   <= (widx == 3'd7);
        widx            <= widx + 3'd1;
        if (widx == 3'd7) begin
          cnt <= 64'd0;
          for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::h_init(3'(i));
        end
      end else if (!dig_stall) begin
        dig_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sha_checker.sv @@
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the SHA-256 hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_message_hasher_macros.svh"

module sha_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          msg_valid,
  input wire logic          msg_stall,
  input wire sha_pkg::msg_t msg,
  input wire logic          dig_valid,
  input wire logic          dig_stall,
  input wire sha_pkg::dig_t dig
);

  `SHA_ASSERT_NEXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(dig), "digest dropped while stalled")
  `SHA_ASSERT_SAME(a_last_idx, dig_valid && dig.last_word, dig.word_index == 3'd7, "last word not index 7")
  `SHA_ASSERT_NEXT(a_burst, dig_valid && !dig_stall && !dig.last_word, dig_valid && dig.word_index == $past(dig.word_index) + 3'd1, "digest burst gap")
  `SHA_ASSERT_NEXT(a_end_busy, msg_valid && !msg_stall && msg.end_of_message, msg_stall, "input taken during finish")

endmodule

bind sha256_message_hasher sha_checker u_chk (.*);

`default_nettype wire
